>>> rtl/gcdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gcdp_pkg;

  localparam int CORDIC_STAGES = 32;
  localparam int TAB_LEN = 40;
  localparam int NSTG = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
  localparam int SQ_STEPS = 31;

  localparam logic [31:0] KINV_Q30 = 32'd652032874;
  localparam logic [30:0] DIST_K = 31'd1800081977;
  localparam logic [31:0] ONE_Q30 = 32'd1073741824;

  function automatic logic [29:0] atan_ent(input int i);
    logic [29:0] v;
    case (i)
      0: v = 30'd536870912;
      1: v = 30'd316933406;
      2: v = 30'd167458907;
      3: v = 30'd85004756;
      4: v = 30'd42667331;
      5: v = 30'd21354465;
      6: v = 30'd10679838;
      7: v = 30'd5340245;
      8: v = 30'd2670163;
      9: v = 30'd1335087;
      10: v = 30'd667544;
      11: v = 30'd333772;
      12: v = 30'd166886;
      13: v = 30'd83443;
      14: v = 30'd41722;
      15: v = 30'd20861;
      16: v = 30'd10430;
      17: v = 30'd5215;
      18: v = 30'd2608;
      19: v = 30'd1304;
      20: v = 30'd652;
      21: v = 30'd326;
      22: v = 30'd163;
      23: v = 30'd81;
      24: v = 30'd41;
      25: v = 30'd20;
      26: v = 30'd10;
      27: v = 30'd5;
      28: v = 30'd3;
      29: v = 30'd1;
      30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [33:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b + 64'sd536870912;
    return p[63:30];
  endfunction

endpackage
`default_nettype wire

>>> rtl/great_circle_destination_point.sv
`timescale 1ns / 1ps
`default_nettype none
// Great-circle destination point. Each input beat carries a start latitude,
// start longitude, bearing (binary angles, 2^32 per turn) and a distance in
// meters; each output beat carries the destination latitude and longitude.
// Channels use valid/stall: a beat moves on a clock edge with valid high and
// stall low. One output beat per input beat, in order.
// The datapath is one fully pipelined chain: distance scaling, three
// rotation CORDICs (sin/cos of latitude, distance angle, bearing), three
// product stages, a 31-step pipelined square root and two vectoring CORDICs
// for the asin and the longitude offset.
// The CORDIC stage count is CORDIC_STAGES, capped at 40 (TAB_LEN).
// Throughput: one beat per cycle while no valid output is stalled.
// When the receiver stalls a valid output, the whole chain holds, empty
// slots included, and in_stall rises in the same cycle.
// Reset (rst_n low, synchronous) clears all valid bits; no beat is in
// flight afterwards.
module great_circle_destination_point (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_start_lat,
  input  wire logic signed [31:0] in_start_lon,
  input  wire logic [31:0]        in_bearing,
  input  wire logic [24:0]        in_distance_m,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_dest_lat,
  output logic signed [31:0]      out_dest_lon
);

  localparam int NS = gcdp_pkg::NSTG;
  localparam int SQ = gcdp_pkg::SQ_STEPS;
  localparam int Q0 = NS + 6;
  localparam int QE = Q0 + SQ;
  localparam int V0 = QE + 1;
  localparam int VE = V0 + NS;
  localparam int LAT = VE + 2;

  logic en;
  logic [LAT-1:0] vld_r;
  logic signed [31:0] lon_r [0:VE];

  logic [56:0] dang_prod;
  logic [31:0] a_lat_r, a_br_r, a_dang_r;

  logic [31:0] rang [0:2];
  logic signed [33:0] rz0 [0:2];
  logic rfold [0:2];
  logic signed [33:0] rx_r [0:2][0:NS];
  logic signed [33:0] ry_r [0:2][0:NS];
  logic signed [33:0] rz_r [0:2][0:NS];
  logic rneg_r [0:2][0:NS];

  logic signed [31:0] p0_s_r [0:2];
  logic signed [31:0] p0_c_r [0:2];

  logic signed [33:0] m1_p1_r, m1_t_r, m1_u_r;
  logic signed [31:0] m1_cb_r, m1_c1_r, m1_s1_r, m1_cd_r;
  logic signed [33:0] s2_raw;
  logic signed [31:0] s2_nxt;
  logic signed [31:0] m2_s2_r, m2_s1_r, m2_cd_r;
  logic signed [33:0] m2_y_r;
  logic signed [63:0] sq_full;
  logic [60:0] m3_sq_r;
  logic signed [33:0] m3_x_r, m3_y_r;
  logic signed [31:0] m3_s2_r;

  logic [61:0] q_rem_r [0:SQ];
  logic [61:0] q_root_r [0:SQ];
  logic signed [31:0] q_s2_r [0:SQ];
  logic signed [33:0] q_x_r [0:SQ];
  logic signed [33:0] q_y_r [0:SQ];

  logic signed [35:0] vx0 [0:1];
  logic signed [35:0] vy0 [0:1];
  logic signed [35:0] vx_r [0:1][0:NS];
  logic signed [35:0] vy_r [0:1][0:NS];
  logic signed [33:0] vz_r [0:1][0:NS];
  logic vzero_r [0:1][0:NS];
  logic vhalf_r [0:1][0:NS];

  logic signed [34:0] zt_lat, zt_lon;
  logic signed [31:0] lat_nxt, dlon;
  logic signed [31:0] out_dest_lat_r, out_dest_lon_r;

  assign en = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld_r[LAT-1];
  assign out_dest_lat = out_dest_lat_r;
  assign out_dest_lon = out_dest_lon_r;

  assign dang_prod = 57'(in_distance_m) * 57'(gcdp_pkg::DIST_K) + 57'(24'h800000);

  always_comb begin
    rang[0] = a_lat_r;
    rang[1] = a_dang_r;
    rang[2] = a_br_r;
    for (int u = 0; u < 3; u++) begin
      rfold[u] = (rang[u][31:30] == 2'b01) || (rang[u][31:30] == 2'b10);
      rz0[u] = $signed({{2{rang[u][31] ^ rfold[u]}}, rang[u][31] ^ rfold[u],
                        rang[u][30:0]});
    end
  end

  always_comb begin
    s2_raw = m1_p1_r + gcdp_pkg::mulq(32'(m1_t_r), m1_cb_r);
    if (s2_raw > $signed({2'b00, gcdp_pkg::ONE_Q30})) begin
      s2_nxt = $signed(gcdp_pkg::ONE_Q30);
    end else if (s2_raw < -$signed({2'b00, gcdp_pkg::ONE_Q30})) begin
      s2_nxt = -$signed(gcdp_pkg::ONE_Q30);
    end else begin
      s2_nxt = 32'(s2_raw);
    end
    sq_full = m2_s2_r * m2_s2_r;
  end

  always_comb begin
    vx0[0] = $signed({5'b0, q_root_r[SQ][30:0]});
    vy0[0] = 36'(q_s2_r[SQ]);
    vx0[1] = 36'(q_x_r[SQ]);
    vy0[1] = 36'(q_y_r[SQ]);
    zt_lat = 35'(vz_r[0][NS]) + (vhalf_r[0][NS] ? 35'sd2147483648 : 35'sd0);
    zt_lon = 35'(vz_r[1][NS]) + (vhalf_r[1][NS] ? 35'sd2147483648 : 35'sd0);
    if (vzero_r[0][NS]) begin
      lat_nxt = '0;
    end else if (zt_lat > 35'sd1073741824) begin
      lat_nxt = 32'sd1073741824;
    end else if (zt_lat < -35'sd1073741824) begin
      lat_nxt = -32'sd1073741824;
    end else begin
      lat_nxt = 32'(zt_lat);
    end
    dlon = vzero_r[1][NS] ? 32'sd0 : $signed(zt_lon[31:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lon_r[0] <= in_start_lon;
      for (int k = 0; k < VE; k++) begin
        lon_r[k+1] <= lon_r[k];
      end

      a_lat_r <= in_start_lat;
      a_br_r <= in_bearing;
      a_dang_r <= dang_prod[55:24];

      for (int u = 0; u < 3; u++) begin
        rx_r[u][0] <= 34'(gcdp_pkg::KINV_Q30);
        ry_r[u][0] <= '0;
        rz_r[u][0] <= rz0[u];
        rneg_r[u][0] <= rfold[u];
        for (int i = 0; i < NS; i++) begin
          rneg_r[u][i+1] <= rneg_r[u][i];
          if (!rz_r[u][i][33]) begin
            rx_r[u][i+1] <= rx_r[u][i] - (ry_r[u][i] >>> i);
            ry_r[u][i+1] <= ry_r[u][i] + (rx_r[u][i] >>> i);
            rz_r[u][i+1] <= rz_r[u][i] - $signed({4'b0, gcdp_pkg::atan_ent(i)});
          end else begin
            rx_r[u][i+1] <= rx_r[u][i] + (ry_r[u][i] >>> i);
            ry_r[u][i+1] <= ry_r[u][i] - (rx_r[u][i] >>> i);
            rz_r[u][i+1] <= rz_r[u][i] + $signed({4'b0, gcdp_pkg::atan_ent(i)});
          end
        end
        p0_c_r[u] <= 32'(rneg_r[u][NS] ? -rx_r[u][NS] : rx_r[u][NS]);
        p0_s_r[u] <= 32'(rneg_r[u][NS] ? -ry_r[u][NS] : ry_r[u][NS]);
      end

      m1_p1_r <= gcdp_pkg::mulq(p0_s_r[0], p0_c_r[1]);
      m1_t_r <= gcdp_pkg::mulq(p0_c_r[0], p0_s_r[1]);
      m1_u_r <= gcdp_pkg::mulq(p0_s_r[2], p0_s_r[1]);
      m1_cb_r <= p0_c_r[2];
      m1_c1_r <= p0_c_r[0];
      m1_s1_r <= p0_s_r[0];
      m1_cd_r <= p0_c_r[1];

      m2_s2_r <= s2_nxt;
      m2_y_r <= gcdp_pkg::mulq(32'(m1_u_r), m1_c1_r);
      m2_s1_r <= m1_s1_r;
      m2_cd_r <= m1_cd_r;

      m3_sq_r <= sq_full[60:0];
      m3_x_r <= 34'(m2_cd_r) - gcdp_pkg::mulq(m2_s1_r, m2_s2_r);
      m3_y_r <= m2_y_r;
      m3_s2_r <= m2_s2_r;

      q_rem_r[0] <= (62'd1 << 60) - 62'(m3_sq_r);
      q_root_r[0] <= '0;
      q_s2_r[0] <= m3_s2_r;
      q_x_r[0] <= m3_x_r;
      q_y_r[0] <= m3_y_r;
      for (int k = 0; k < SQ; k++) begin
        q_s2_r[k+1] <= q_s2_r[k];
        q_x_r[k+1] <= q_x_r[k];
        q_y_r[k+1] <= q_y_r[k];
        if (q_rem_r[k] >= q_root_r[k] + (62'd1 << (2 * (SQ - 1 - k)))) begin
          q_rem_r[k+1] <= q_rem_r[k] - q_root_r[k] - (62'd1 << (2 * (SQ - 1 - k)));
          q_root_r[k+1] <= (q_root_r[k] >> 1) + (62'd1 << (2 * (SQ - 1 - k)));
        end else begin
          q_rem_r[k+1] <= q_rem_r[k];
          q_root_r[k+1] <= q_root_r[k] >> 1;
        end
      end

      for (int u = 0; u < 2; u++) begin
        vzero_r[u][0] <= (vx0[u] == '0) && (vy0[u] == '0);
        vhalf_r[u][0] <= vx0[u][35];
        vx_r[u][0] <= vx0[u][35] ? -vx0[u] : vx0[u];
        vy_r[u][0] <= vx0[u][35] ? -vy0[u] : vy0[u];
        vz_r[u][0] <= '0;
        for (int i = 0; i < NS; i++) begin
          vzero_r[u][i+1] <= vzero_r[u][i];
          vhalf_r[u][i+1] <= vhalf_r[u][i];
          if (!vy_r[u][i][35]) begin
            vx_r[u][i+1] <= vx_r[u][i] + (vy_r[u][i] >>> i);
            vy_r[u][i+1] <= vy_r[u][i] - (vx_r[u][i] >>> i);
            vz_r[u][i+1] <= vz_r[u][i] + $signed({4'b0, gcdp_pkg::atan_ent(i)});
          end else begin
            vx_r[u][i+1] <= vx_r[u][i] - (vy_r[u][i] >>> i);
            vy_r[u][i+1] <= vy_r[u][i] + (vx_r[u][i] >>> i);
            vz_r[u][i+1] <= vz_r[u][i] - $signed({4'b0, gcdp_pkg::atan_ent(i)});
          end
        end
      end

      out_dest_lat_r <= lat_nxt;
      out_dest_lon_r <= lon_r[VE] + dlon;
    end
  end

  a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dest_lat <= 32'sd1073741824) && (out_dest_lat >= -32'sd1073741824))
    else $error("destination latitude beyond a quarter turn");

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QE] |-> (q_root_r[SQ] <= 62'd1073741824))
    else $error("cos(lat2) root out of range");

  a_vec_x_pos: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[VE] |-> !vx_r[0][NS][35])
    else $error("asin vectoring x went negative");

  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire
